[hdl/sli_pkg.sv]
// Shared types and constants for the sorted list store.
// Used by the storage cell and the top level; depends on nothing else.
package sli_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic       CMD_INSERT = 1'b0;
    localparam logic       CMD_DELETE = 1'b1;

    localparam logic [1:0] ST_INSERTED  = 2'd0;
    localparam logic [1:0] ST_DELETED   = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic               cmd;
        logic signed [31:0] value;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] position;
        logic [4:0] count;
    } rsp_t;

    // Control broadcast from the sequencer to every cell.
    typedef struct packed {
        logic cmp_en;
        logic upd_en;
        logic del;
    } cell_ctl_t;

endpackage

[hdl/sli_cell.sv]
// One storage cell of the sorted list: holds one entry and its compare flag.
// Depends on sli_pkg for the control struct.
module sli_cell (
    input  logic                clk,
    input  sli_pkg::cell_ctl_t  ctl,
    input  logic                occ,
    input  logic signed [31:0]  value,
    input  logic signed [31:0]  left_entry,
    input  logic signed [31:0]  right_entry,
    input  logic                hit_in,
    output logic signed [31:0]  entry,
    output logic                hit_out,
    output logic                first
);

    logic signed [31:0] entry_reg;
    logic signed [31:0] entry_next;
    logic               hit_reg;
    logic               hit_next;

    // The compare flag marks the insertion point (first entry not less than
    // the value, or an empty slot) or a delete match.
    always_comb
    begin
        hit_next = hit_reg;
        if (ctl.cmp_en)
        begin
            if (ctl.del)
                hit_next = occ && (entry_reg == value);
            else
                hit_next = !occ || !(entry_reg < value);
        end
    end

    assign first   = hit_reg && !hit_in;
    assign hit_out = hit_reg || hit_in;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.upd_en)
        begin
            if (ctl.del)
            begin
                if (hit_out)
                    entry_next = right_entry;
            end
            else if (first)
                entry_next = value;
            else if (hit_in)
                entry_next = left_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        hit_reg   <= hit_next;
    end

    assign entry = entry_reg;

endmodule

[hdl/sorted_list_insert_delete.sv]
// Sorted list store: a row of cells keeps signed values in ascending order.
// A command is captured, compared against every cell in the compare state, and
// applied in the shift state, where its result is registered and then shown for
// one cycle on done. A new command may be accepted in the shift state.
// Reset clears the entry count and the sequencer; cell contents are not reset.
// The receiver cannot stall; done is a one-cycle strobe.
module sorted_list_insert_delete (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  sli_pkg::req_t  req,
    output logic           done,
    output sli_pkg::rsp_t  rsp
);

    // Sequencer states.
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;

    logic [1:0]                 state_reg;
    logic [1:0]                 state_next;
    sli_pkg::req_t              op_reg;
    logic [sli_pkg::CNT_W-1:0]  count_reg;
    logic [sli_pkg::CNT_W-1:0]  count_next;
    logic                       done_reg;
    sli_pkg::rsp_t              rsp_reg;
    sli_pkg::rsp_t              rsp_next;

    logic                       accept;
    logic                       full;
    sli_pkg::cell_ctl_t         ctl;

    logic signed [31:0]         entry [sli_pkg::CAPACITY];
    logic [sli_pkg::CAPACITY:0] hit_chain;
    logic [sli_pkg::CAPACITY-1:0] first;
    logic [sli_pkg::CAPACITY-1:0] occ;
    logic [sli_pkg::IDX_W-1:0]  pos;
    logic                       found;

    // A new command may enter while the previous one is doing its shift
    // cycle: the shift and the new command's capture happen at the same edge,
    // and the compare of the new command sees the updated row.
    assign busy   = (state_reg == S_CMP);
    assign accept = start && !busy;
    assign full   = (count_reg >= sli_pkg::CNT_W'(sli_pkg::CAPACITY));

    always_comb
    begin
        ctl.cmp_en = (state_reg == S_CMP);
        ctl.del    = (op_reg.cmd == sli_pkg::CMD_DELETE);
        // An insert into a full row is dropped, so nothing shifts.
        ctl.upd_en = (state_reg == S_UPD) && !(!ctl.del && full);
    end

    // Each cell learns whether it holds a live entry from the count.
    always_comb
    begin
        for (int i = 0; i < sli_pkg::CAPACITY; i++)
            occ[i] = (sli_pkg::CNT_W'(i) < count_reg);
    end

    assign hit_chain[0] = 1'b0;

    for (genvar g = 0; g < sli_pkg::CAPACITY; g++)
    begin : g_cell
        logic signed [31:0] left_e;
        logic signed [31:0] right_e;

        if (g == 0)
        begin : g_first
            assign left_e = op_reg.value;
        end
        else
        begin : g_mid_l
            assign left_e = entry[g-1];
        end

        if (g == sli_pkg::CAPACITY - 1)
        begin : g_last
            assign right_e = entry[g];
        end
        else
        begin : g_mid_r
            assign right_e = entry[g+1];
        end

        sli_cell u_cell (
            .clk         (clk),
            .ctl         (ctl),
            .occ         (occ[g]),
            .value       (op_reg.value),
            .left_entry  (left_e),
            .right_entry (right_e),
            .hit_in      (hit_chain[g]),
            .entry       (entry[g]),
            .hit_out     (hit_chain[g+1]),
            .first       (first[g])
        );
    end

    assign found = hit_chain[sli_pkg::CAPACITY];

    // Encode the one-hot first-hit vector into an index.
    always_comb
    begin
        pos = '0;
        for (int i = 0; i < sli_pkg::CAPACITY; i++)
        begin
            if (first[i])
                pos = pos | sli_pkg::IDX_W'(i);
        end
    end

    // Result and count for the command in its shift cycle.
    always_comb
    begin
        count_next = count_reg;
        rsp_next   = rsp_reg;
        if (state_reg == S_UPD)
        begin
            rsp_next.position = 4'd0;
            if (!ctl.del)
            begin
                if (full)
                    rsp_next.status = sli_pkg::ST_FULL;
                else
                begin
                    rsp_next.status   = sli_pkg::ST_INSERTED;
                    rsp_next.position = 4'(pos);
                    count_next        = count_reg + sli_pkg::CNT_W'(1);
                end
            end
            else if (found)
            begin
                rsp_next.status   = sli_pkg::ST_DELETED;
                rsp_next.position = 4'(pos);
                count_next        = count_reg - sli_pkg::CNT_W'(1);
            end
            else
                rsp_next.status = sli_pkg::ST_NOT_FOUND;
            rsp_next.count = 5'(count_next);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  state_next = accept ? S_CMP : S_IDLE;
            S_CMP:   state_next = S_UPD;
            S_UPD:   state_next = accept ? S_CMP : S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= (state_reg == S_UPD);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            op_reg <= req;
        rsp_reg <= rsp_next;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

[sim/sli_check_pkg.sv]
// Scoreboard for the sorted list store: a shadow copy of the list and the queue
// of responses it predicts. Depends on sli_pkg for the beat types and codes.
`timescale 1ns / 1ps

package sli_check_pkg;

    class list_scoreboard;

        logic signed [31:0] shadow_list[$];
        sli_pkg::rsp_t      expected_rsp[$];
        int unsigned        mismatches;

        function new();
            mismatches = 0;
        endfunction

        // Applies one command to the shadow list and returns the response it must give.
        function sli_pkg::rsp_t predict_response(sli_pkg::req_t r);
            sli_pkg::rsp_t      rsp;
            logic signed [31:0] v;
            int                 idx;
            bit                 hit;
            rsp = '0;
            v   = r.value;
            idx = 0;
            hit = 1'b0;
            if (r.cmd == sli_pkg::CMD_INSERT)
            begin
                if (shadow_list.size() >= sli_pkg::CAPACITY)
                begin
                    rsp.status = sli_pkg::ST_FULL;
                end
                else
                begin
                    while (idx < shadow_list.size() && shadow_list[idx] < v)
                        idx++;
                    shadow_list.insert(idx, v);
                    rsp.status   = sli_pkg::ST_INSERTED;
                    rsp.position = 4'(idx);
                end
            end
            else
            begin
                while (idx < shadow_list.size() && !hit)
                begin
                    if (shadow_list[idx] == v)
                        hit = 1'b1;
                    else
                        idx++;
                end
                if (hit)
                begin
                    shadow_list.delete(idx);
                    rsp.status   = sli_pkg::ST_DELETED;
                    rsp.position = 4'(idx);
                end
                else
                begin
                    rsp.status = sli_pkg::ST_NOT_FOUND;
                end
            end
            rsp.count = 5'(shadow_list.size());
            return rsp;
        endfunction

        function void note_command(sli_pkg::req_t r);
            expected_rsp.push_back(predict_response(r));
        endfunction

        function void check_response(sli_pkg::rsp_t got);
            sli_pkg::rsp_t want;
            if (expected_rsp.size() == 0)
            begin
                $error("response with nothing expected: status=%0d position=%0d count=%0d",
                       got.status, got.position, got.count);
                mismatches++;
                return;
            end
            want = expected_rsp.pop_front();
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                mismatches++;
            end
            if (got.position !== want.position)
            begin
                $error("position: expected %0d, got %0d", want.position, got.position);
                mismatches++;
            end
            if (got.count !== want.count)
            begin
                $error("count: expected %0d, got %0d", want.count, got.count);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_rsp.size();
        endfunction

        // A value now in the list, so that a delete can hit; the fallback if the list is empty.
        function logic signed [31:0] pick_stored(logic signed [31:0] fallback);
            if (shadow_list.size() == 0)
                return fallback;
            return shadow_list[$urandom_range(shadow_list.size() - 1)];
        endfunction

    endclass

endpackage

[sim/tb_sorted_list_insert_delete.sv]
// Testbench top for sorted_list_insert_delete: directed and random insert and
// delete commands, checked beat by beat. Depends on sli_pkg and sli_check_pkg.
`timescale 1ns / 1ps

module tb_sorted_list_insert_delete;

    // Cycles with no beat in either direction before the run is declared hung.
    // Sender gaps are geometric, so a correct run never comes anywhere near this.
    localparam int HANG_LIMIT = 2000;

    localparam logic signed [31:0] MOST_NEG = 32'sh8000_0000;
    localparam logic signed [31:0] MOST_POS = 32'sh7FFF_FFFF;

    logic           clk = 1'b0;
    logic           rst_n;
    logic           start;
    logic           busy;
    sli_pkg::req_t  req;
    logic           done;
    sli_pkg::rsp_t  rsp;

    sli_check_pkg::list_scoreboard sb;
    int                            sender_idle_pct;

    sorted_list_insert_delete u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Observation at the rising edge. The block updates its outputs with
    // nonblocking assignments, so the values read here are the ones that held
    // during the cycle the edge closes. A command is noted before a response
    // is checked, so a response can never overtake its own expectation.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                sb.note_command(req);
            if (done)
                sb.check_response(rsp);
        end
    end

    // Watchdog: counts edges at which neither a command nor a response beat
    // moved, and gives up once the count reaches the limit.
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < HANG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (start && !busy) || done)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // Drives one command beat. Inputs change only at the falling edge; start
    // stays high from one command to the next unless the sender idles, and
    // the task returns at the rising edge at which the beat was taken.
    task automatic send_command(input logic c, input logic signed [31:0] v);
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start = 1'b0;
            @(negedge clk);
        end
        start     = 1'b1;
        req.cmd   = c;
        req.value = v;
        do
            @(posedge clk);
        while (busy);
    endtask

    // The sender holds off until every response it is owed has come back.
    task automatic drain_results();
        @(negedge clk);
        start = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Random commands. The insert share swings between high and low every 64
    // commands, so the list keeps running up to full and back down to empty.
    // Two values in five come from a narrow band, which gives duplicates and delete
    // hits; half of the deletes aim at a value known to be in the list. Fully
    // random values make every bit of the value field toggle.
    task automatic run_random(input int n, input int idle_pct);
        sender_idle_pct = idle_pct;
        for (int k = 0; k < n; k++)
        begin
            int                 insert_share;
            int                 roll;
            logic               c;
            logic signed [31:0] v;
            insert_share = ((k / 64) % 2 == 0) ? 70 : 30;
            c    = ($urandom_range(99) < insert_share) ? sli_pkg::CMD_INSERT
                                                       : sli_pkg::CMD_DELETE;
            roll = $urandom_range(99);
            if (roll < 40)
            begin
                v = $signed(32'($urandom_range(8))) - 32'sd4;
            end
            else if (roll < 50)
            begin
                case ($urandom_range(3))
                    0:       v = MOST_NEG;
                    1:       v = MOST_POS;
                    2:       v = 32'sd0;
                    default: v = -32'sd1;
                endcase
            end
            else
            begin
                v = $signed($urandom);
            end
            if (c == sli_pkg::CMD_DELETE && $urandom_range(99) < 50)
                v = sb.pick_stored(v);
            send_command(c, v);
        end
    endtask

    initial
    begin
        sb              = new();
        sender_idle_pct = 0;
        rst_n           = 1'b0;
        start           = 1'b0;
        req             = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part, back to back. A delete on the empty list must report
        // not found; the extremes of the value range go in at both ends.
        send_command(sli_pkg::CMD_DELETE, 32'sd5);
        send_command(sli_pkg::CMD_INSERT, 32'sd0);
        send_command(sli_pkg::CMD_INSERT, MOST_POS);
        send_command(sli_pkg::CMD_INSERT, MOST_NEG);
        send_command(sli_pkg::CMD_INSERT, -32'sd1);
        send_command(sli_pkg::CMD_INSERT, 32'sd1);
        // An equal value goes in front of the one already stored.
        send_command(sli_pkg::CMD_INSERT, 32'sd0);
        send_command(sli_pkg::CMD_DELETE, 32'sd0);
        // A miss on a non-empty list leaves it untouched.
        send_command(sli_pkg::CMD_DELETE, 32'sd7);
        // Fill the list to capacity with values spread around the others.
        for (int i = 0; i < sli_pkg::CAPACITY - 5; i++)
            send_command(sli_pkg::CMD_INSERT, $signed(32'(i * 1000 - 5000)));
        // Insert into a full list is dropped and flagged.
        send_command(sli_pkg::CMD_INSERT, 32'sh5555_5555);
        send_command(sli_pkg::CMD_DELETE, MOST_POS);
        send_command(sli_pkg::CMD_DELETE, MOST_NEG);
        send_command(sli_pkg::CMD_INSERT, MOST_NEG);
        send_command(sli_pkg::CMD_DELETE, -32'sd1);
        drain_results();

        // Random phases: no idling, a mostly idle sender, light idling, and
        // a last stretch with none, with full pauses between them.
        run_random(450, 0);
        drain_results();
        run_random(450, 78);
        drain_results();
        run_random(450, 15);
        drain_results();
        run_random(450, 0);
        drain_results();

        // Let the clock run on to catch any response that should not come.
        repeat (8) @(posedge clk);
        if (sb.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
